>>> hdl/fipg_pkg.sv
// ----------------------------------------------------------------------------
// fipg_pkg
// Shared types, constants and map coefficient table for the fern IFS point
// generator.
// ----------------------------------------------------------------------------
package fipg_pkg;

    localparam int FRAC_BITS_DEF   = 24;
    localparam int RANDOM_BITS_DEF = 16;

    localparam int INT_BITS    = 8;
    localparam int ORIGIN_BITS = 32;
    localparam int ORIGIN_FRAC = 24;
    localparam int WIN_BITS    = 13;
    localparam int PIX_BITS    = 16;
    localparam int COEF_BITS   = 17;
    localparam int COEF_FRAC   = 16;

    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(800);

    localparam int THR_SCALE = 100;
    localparam int THR_STEM  = 1;
    localparam int THR_LEAF  = 86;
    localparam int THR_LEFT  = 93;
    localparam int THR_EXTRA = 7;

    localparam int PIX_SCALE = 10;

    // floor(m / 10) as (m * DIV10_MUL) >> DIV10_SHIFT, exact for m < 2^23
    localparam int DIV10_SHIFT = 26;
    localparam int DIV10_BITS  = 23;
    localparam logic [DIV10_BITS-1:0] DIV10_MUL =
        DIV10_BITS'((2 ** DIV10_SHIFT + 9) / 10);

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MONO      = 3'd5;

    typedef enum logic [1:0] {
        MAP_STEM,
        MAP_LEAF,
        MAP_LEFT,
        MAP_RIGHT
    } map_t;

    typedef enum logic [1:0] {
        OFS_NONE,
        OFS_1P6,
        OFS_0P44
    } ofs_t;

    typedef enum logic [1:0] {
        COLOR_GREEN,
        COLOR_GREY8,
        COLOR_PURPLE,
        COLOR_GREY2
    } color_t;

    typedef struct packed {
        map_t map;
        logic restart;
    } cmd_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] ax;
        logic signed [COEF_BITS-1:0] bx;
        logic signed [COEF_BITS-1:0] ay;
        logic signed [COEF_BITS-1:0] by;
        ofs_t                        ofs;
    } coef_t;

    // Q.16 coefficients of the four fern maps
    function automatic coef_t map_coef(input map_t m);
        coef_t c;
        unique case (m)
            MAP_STEM: begin
                c.ax = COEF_BITS'(0);
                c.bx = COEF_BITS'(0);
                c.ay = COEF_BITS'(0);
                c.by = COEF_BITS'(10486);
                c.ofs = OFS_NONE;
            end
            MAP_LEAF: begin
                c.ax = COEF_BITS'(55706);
                c.bx = COEF_BITS'(2621);
                c.ay = -COEF_BITS'(2621);
                c.by = COEF_BITS'(55706);
                c.ofs = OFS_1P6;
            end
            MAP_LEFT: begin
                c.ax = COEF_BITS'(13107);
                c.bx = -COEF_BITS'(17039);
                c.ay = COEF_BITS'(15073);
                c.by = COEF_BITS'(14418);
                c.ofs = OFS_1P6;
            end
            default: begin
                c.ax = -COEF_BITS'(9830);
                c.bx = COEF_BITS'(18350);
                c.ay = COEF_BITS'(17039);
                c.by = COEF_BITS'(15729);
                c.ofs = OFS_0P44;
            end
        endcase
        return c;
    endfunction

endpackage

>>> hdl/fern_ifs_point_generator_core.sv
// ----------------------------------------------------------------------------
// fern_ifs_point_generator_core
// Barnsley fern chaos game: one fern point and its pixel per input word.
// The point update loop (coefficient multiply, then sum, offset and
//   saturate into the point) sets the word rate; it takes no new word
//   until the last point is written back. A full result register stalls
//   the back end; the two-entry queue keeps taking input words until full.
// Reset clears point, config (width/height 800) and all valid state.
// ----------------------------------------------------------------------------
module fern_ifs_point_generator_core
    import fipg_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [RANDOM_BITS-1:0]      s_random_fraction,
    input  logic                        s_restart,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [PIX_BITS-1:0]  m_pixel_x,
    output logic signed [PIX_BITS-1:0]  m_pixel_y,
    output logic                        m_in_window,
    output logic [1:0]                  m_color_code
);

    localparam int PW = FRAC_BITS + INT_BITS;

    logic signed [ORIGIN_BITS-1:0] origin_x_reg, origin_y_reg;
    logic [WIN_BITS-1:0]           width_reg, height_reg;
    logic                          invert_reg, mono_reg;

    logic signed [PW-1:0] origin_x_s, origin_y_s;

    logic                 q_push, q_full, q_pop, q_valid;
    cmd_t                 push_cmd, pop_cmd;
    logic                 adv;
    logic                 pt_valid;
    logic signed [PW-1:0] pt_x, pt_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            width_reg    <= WIN_RESET;
            height_reg   <= WIN_RESET;
            invert_reg   <= 1'b0;
            mono_reg     <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_wr_data;
                REG_ORIGIN_Y: origin_y_reg <= cfg_wr_data;
                REG_WIDTH:    width_reg    <= cfg_wr_data[WIN_BITS-1:0];
                REG_HEIGHT:   height_reg   <= cfg_wr_data[WIN_BITS-1:0];
                REG_INVERT:   invert_reg   <= cfg_wr_data[0];
                REG_MONO:     mono_reg     <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Q8.24 origin rescaled to the point format, floor on dropped bits
    generate
        if (FRAC_BITS >= ORIGIN_FRAC) begin : g_origin_up
            assign origin_x_s = PW'(origin_x_reg) <<< (FRAC_BITS - ORIGIN_FRAC);
            assign origin_y_s = PW'(origin_y_reg) <<< (FRAC_BITS - ORIGIN_FRAC);
        end else begin : g_origin_down
            assign origin_x_s = PW'(origin_x_reg >>> (ORIGIN_FRAC - FRAC_BITS));
            assign origin_y_s = PW'(origin_y_reg >>> (ORIGIN_FRAC - FRAC_BITS));
        end
    endgenerate

    fipg_front #(
        .RANDOM_BITS(RANDOM_BITS)
    ) u_front (
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_random_fraction(s_random_fraction),
        .s_restart        (s_restart),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (push_cmd)
    );

    fipg_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_cmd(push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .pop_cmd (pop_cmd)
    );

    fipg_point #(
        .FRAC_BITS(FRAC_BITS)
    ) u_point (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .origin_x (origin_x_s),
        .origin_y (origin_y_s),
        .adv      (adv),
        .out_valid(pt_valid),
        .out_x    (pt_x),
        .out_y    (pt_y)
    );

    fipg_pixel #(
        .FRAC_BITS(FRAC_BITS)
    ) u_pixel (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (pt_valid),
        .in_x         (pt_x),
        .in_y         (pt_y),
        .origin_x     (origin_x_s),
        .origin_y     (origin_y_s),
        .image_width  (width_reg),
        .image_height (height_reg),
        .invert_colors(invert_reg),
        .monochrome   (mono_reg),
        .adv          (adv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_in_window  (m_in_window),
        .m_color_code (m_color_code)
    );

endmodule

>>> hdl/fipg_front.sv
// ----------------------------------------------------------------------------
// fipg_front
// Input side: takes words while the queue has room and picks the fern map
// from the random fraction.
// ----------------------------------------------------------------------------
module fipg_front
    import fipg_pkg::*;
#(
    parameter int RANDOM_BITS = RANDOM_BITS_DEF
) (
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [RANDOM_BITS-1:0] s_random_fraction,
    input  logic                   s_restart,
    input  logic                   q_full,
    output logic                   q_push,
    output cmd_t                   q_cmd
);

    localparam int RW = RANDOM_BITS + THR_EXTRA;

    localparam logic [RW-1:0] LIM_STEM = RW'(THR_STEM) << RANDOM_BITS;
    localparam logic [RW-1:0] LIM_LEAF = RW'(THR_LEAF) << RANDOM_BITS;
    localparam logic [RW-1:0] LIM_LEFT = RW'(THR_LEFT) << RANDOM_BITS;

    logic [RW-1:0] r_scaled;

    assign r_scaled = RW'(s_random_fraction) * RW'(THR_SCALE);

    always_comb begin
        q_cmd.restart = s_restart;
        priority if (r_scaled < LIM_STEM) begin
            q_cmd.map = MAP_STEM;
        end else if (r_scaled < LIM_LEAF) begin
            q_cmd.map = MAP_LEAF;
        end else if (r_scaled < LIM_LEFT) begin
            q_cmd.map = MAP_LEFT;
        end else begin
            q_cmd.map = MAP_RIGHT;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

endmodule

>>> hdl/fipg_queue.sv
// ----------------------------------------------------------------------------
// fipg_queue
// Short command queue between the front and the point update unit.
// ----------------------------------------------------------------------------
module fipg_queue
    import fipg_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t pop_cmd
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    cmd_t          mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign valid   = (count_reg != '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> valid)
        else $error("queue pop while empty");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a word");

endmodule

>>> hdl/fipg_point.sv
// ----------------------------------------------------------------------------
// fipg_point
// Point update unit: multiplies the stored point (the origin on a restart)
// by the selected map coefficients, then sums, adds the offset to y and saturates into the point.
// ----------------------------------------------------------------------------
module fipg_point
    import fipg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_valid,
    input  cmd_t                                  q_cmd,
    output logic                                  q_pop,
    input  logic signed [FRAC_BITS+INT_BITS-1:0]  origin_x,
    input  logic signed [FRAC_BITS+INT_BITS-1:0]  origin_y,
    input  logic                                  adv,
    output logic                                  out_valid,
    output logic signed [FRAC_BITS+INT_BITS-1:0]  out_x,
    output logic signed [FRAC_BITS+INT_BITS-1:0]  out_y
);

    localparam int PW  = FRAC_BITS + INT_BITS;
    localparam int PRW = PW + COEF_BITS;
    localparam int SW  = PRW + 1 - COEF_FRAC;
    localparam int YW  = SW + 1;

    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] OFS_1P6_V  = SW'((ONE_L * 8 + 2) / 5);
    localparam logic signed [SW-1:0] OFS_0P44_V = SW'((ONE_L * 11 + 12) / 25);

    localparam logic signed [PW-1:0] PT_MAX = {1'b0, {(PW-1){1'b1}}};
    localparam logic signed [PW-1:0] PT_MIN = {1'b1, {(PW-1){1'b0}}};

    function automatic logic signed [PW-1:0] sat_pt(input logic signed [YW-1:0] v);
        logic [YW-PW:0] top;
        top = v[YW-1:PW-1];
        if (&top || ~|top) begin
            return v[PW-1:0];
        end
        return v[YW-1] ? PT_MIN : PT_MAX;
    endfunction

    logic                    s1_valid_reg;
    logic signed [PRW-1:0]   pax_reg, pbx_reg, pay_reg, pby_reg;
    logic signed [PRW-1:0]   pax_next, pbx_next, pay_next, pby_next;
    ofs_t                    ofs_reg;
    logic signed [PW-1:0]    point_x_reg, point_y_reg;
    logic signed [PW-1:0]    point_x_next, point_y_next;
    logic                    out_valid_reg;
    logic signed [PW-1:0]    out_x_reg, out_y_reg;

    logic signed [PW-1:0]    x_in, y_in;
    coef_t                   coef;
    logic signed [PRW:0]     sum_x, sum_y;
    logic signed [SW-1:0]    sx, sy, ofs_val;
    logic signed [YW-1:0]    ny_full;

    assign q_pop = q_valid && !s1_valid_reg;
    assign coef  = map_coef(q_cmd.map);
    assign x_in  = q_cmd.restart ? origin_x : point_x_reg;
    assign y_in  = q_cmd.restart ? origin_y : point_y_reg;

    assign pax_next = PRW'(x_in) * PRW'(coef.ax);
    assign pbx_next = PRW'(y_in) * PRW'(coef.bx);
    assign pay_next = PRW'(x_in) * PRW'(coef.ay);
    assign pby_next = PRW'(y_in) * PRW'(coef.by);

    always_comb begin
        sum_x = (PRW+1)'(pax_reg) + (PRW+1)'(pbx_reg);
        sum_y = (PRW+1)'(pay_reg) + (PRW+1)'(pby_reg);
        sx = sum_x[PRW:COEF_FRAC];
        sy = sum_y[PRW:COEF_FRAC];
        unique case (ofs_reg)
            OFS_1P6:  ofs_val = OFS_1P6_V;
            OFS_0P44: ofs_val = OFS_0P44_V;
            default:  ofs_val = '0;
        endcase
        ny_full      = YW'(sy) + YW'(ofs_val);
        point_x_next = sat_pt(YW'(sx));
        point_y_next = sat_pt(ny_full);
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            pax_reg <= pax_next;
            pbx_reg <= pbx_next;
            pay_reg <= pay_next;
            pby_reg <= pby_next;
            ofs_reg <= coef.ofs;
        end
        if (adv) begin
            out_x_reg <= point_x_next;
            out_y_reg <= point_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            point_x_reg   <= '0;
            point_y_reg   <= '0;
        end else begin
            if (q_pop) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_valid_reg && adv) begin
                point_x_reg <= point_x_next;
                point_y_reg <= point_y_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && adv) |=> !s1_valid_reg)
        else $error("new update issued before point write");

endmodule

>>> hdl/fipg_pixel.sv
// ----------------------------------------------------------------------------
// fipg_pixel
// Pixel mapping pipeline: offset, scale by window size, divide by ten units,
// saturate, window test and color. Ends in the result register.
// ----------------------------------------------------------------------------
module fipg_pixel
    import fipg_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    input  logic signed [FRAC_BITS+INT_BITS-1:0]  in_x,
    input  logic signed [FRAC_BITS+INT_BITS-1:0]  in_y,
    input  logic signed [FRAC_BITS+INT_BITS-1:0]  origin_x,
    input  logic signed [FRAC_BITS+INT_BITS-1:0]  origin_y,
    input  logic [WIN_BITS-1:0]                   image_width,
    input  logic [WIN_BITS-1:0]                   image_height,
    input  logic                                  invert_colors,
    input  logic                                  monochrome,
    output logic                                  adv,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [PIX_BITS-1:0]            m_pixel_x,
    output logic signed [PIX_BITS-1:0]            m_pixel_y,
    output logic                                  m_in_window,
    output logic [1:0]                            m_color_code
);

    localparam int PW     = FRAC_BITS + INT_BITS;
    localparam int DW     = PW + 2;
    localparam int LO     = DW / 2;
    localparam int HI     = DW - LO;
    localparam int LPW    = LO + WIN_BITS;
    localparam int HPW    = HI + WIN_BITS + 1;
    localparam int NW     = DW + WIN_BITS + 1;
    localparam int TW     = NW - FRAC_BITS;
    localparam int MAG    = TW - 1;
    localparam int PRDW   = MAG + DIV10_BITS;
    localparam int QB     = PRDW - DIV10_SHIFT;
    localparam int KW     = WIN_BITS + 4;
    localparam int STAGES = 6;

    localparam logic signed [DW-1:0] TEN_ONE =
        DW'(longint'(PIX_SCALE) << FRAC_BITS);
    localparam logic [NW-1:0] RMASK = (NW'(1) << FRAC_BITS) - NW'(1);
    localparam logic signed [PIX_BITS-1:0] PIX_MAX = {1'b0, {(PIX_BITS-1){1'b1}}};
    localparam logic signed [PIX_BITS-1:0] PIX_MIN = {1'b1, {(PIX_BITS-1){1'b0}}};

    function automatic logic signed [PIX_BITS-1:0] sat_pix(
        input logic signed [QB:0] v
    );
        logic [QB-PIX_BITS+1:0] top;
        top = v[QB:PIX_BITS-1];
        if (&top || ~|top) begin
            return v[PIX_BITS-1:0];
        end
        return v[QB] ? PIX_MIN : PIX_MAX;
    endfunction

    logic [STAGES-1:0]        vld_reg;

    logic signed [DW-1:0]     dx_reg, ey_reg;
    logic [LPW-1:0]           lox_reg, loy_reg;
    logic signed [HPW-1:0]    hix_reg, hiy_reg;
    logic signed [NW-1:0]     nx_reg, ny_reg;
    logic signed [TW-1:0]     tx_reg, ty_reg;
    logic                     negx_reg, negy_reg;
    logic [PRDW-1:0]          prdx_reg, prdy_reg;
    logic signed [PIX_BITS-1:0] px_reg, py_reg;
    logic                     win_reg;
    color_t                   color_reg;

    logic signed [DW-1:0]     dx_next, ey_next;
    logic [LPW-1:0]           lox_next, loy_next;
    logic signed [HPW-1:0]    hix_next, hiy_next;
    logic [KW-1:0]            kx;
    logic signed [NW-1:0]     nx_next, ny_next;
    logic [NW-1:0]            adjx, adjy;
    logic [TW-1:0]            magx, magy;
    logic [PRDW-1:0]          prdx_next, prdy_next;
    logic [QB-1:0]            qx, qy;
    logic signed [QB:0]       svx, svy;
    logic signed [PIX_BITS-1:0] px_next, py_next;
    logic                     win_next;
    color_t                   color_next;

    assign m_valid = vld_reg[STAGES-1];
    assign adv     = !m_valid || m_ready;

    always_comb begin
        dx_next = DW'(in_x) - DW'(origin_x);
        ey_next = TEN_ONE + DW'(origin_y) - DW'(in_y);

        lox_next = LPW'(dx_reg[LO-1:0]) * LPW'(image_width);
        loy_next = LPW'(ey_reg[LO-1:0]) * LPW'(image_height);
        hix_next = HPW'($signed(dx_reg[DW-1:LO])) * HPW'($signed({1'b0, image_width}));
        hiy_next = HPW'($signed(ey_reg[DW-1:LO])) * HPW'($signed({1'b0, image_height}));

        kx = KW'(image_width[WIN_BITS-1:1]) * KW'(PIX_SCALE);
        nx_next = (NW'(hix_reg) <<< LO) + NW'(lox_reg) + (NW'(kx) << FRAC_BITS);
        ny_next = (NW'(hiy_reg) <<< LO) + NW'(loy_reg);

        // truncate toward zero
        adjx = nx_reg + (nx_reg[NW-1] ? RMASK : '0);
        adjy = ny_reg + (ny_reg[NW-1] ? RMASK : '0);

        magx = tx_reg[TW-1] ? -tx_reg : tx_reg;
        magy = ty_reg[TW-1] ? -ty_reg : ty_reg;
        prdx_next = PRDW'(magx[MAG-1:0]) * PRDW'(DIV10_MUL);
        prdy_next = PRDW'(magy[MAG-1:0]) * PRDW'(DIV10_MUL);

        qx  = prdx_reg[DIV10_SHIFT +: QB];
        qy  = prdy_reg[DIV10_SHIFT +: QB];
        svx = negx_reg ? -(QB+1)'(qx) : (QB+1)'(qx);
        svy = negy_reg ? -(QB+1)'(qy) : (QB+1)'(qy);
        px_next = sat_pix(svx);
        py_next = sat_pix(svy);

        win_next = !px_next[PIX_BITS-1] && !py_next[PIX_BITS-1]
                && ({1'b0, px_next[PIX_BITS-2:0]} < PIX_BITS'(image_width))
                && ({1'b0, py_next[PIX_BITS-2:0]} < PIX_BITS'(image_height));

        if (invert_colors) begin
            color_next = monochrome ? COLOR_GREY2 : COLOR_PURPLE;
        end else begin
            color_next = monochrome ? COLOR_GREY8 : COLOR_GREEN;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg    <= dx_next;
            ey_reg    <= ey_next;
            lox_reg   <= lox_next;
            loy_reg   <= loy_next;
            hix_reg   <= hix_next;
            hiy_reg   <= hiy_next;
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            tx_reg    <= adjx[NW-1:FRAC_BITS];
            ty_reg    <= adjy[NW-1:FRAC_BITS];
            negx_reg  <= tx_reg[TW-1];
            negy_reg  <= ty_reg[TW-1];
            prdx_reg  <= prdx_next;
            prdy_reg  <= prdy_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            win_reg   <= win_next;
            color_reg <= color_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    assign m_pixel_x    = px_reg;
    assign m_pixel_y    = py_reg;
    assign m_in_window  = win_reg;
    assign m_color_code = color_reg;

    a_window_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_in_window) |-> (!m_pixel_x[PIX_BITS-1] && !m_pixel_y[PIX_BITS-1]))
        else $error("in-window pixel with negative coordinate");

endmodule
